FILE: design/glyph_to_vector_commands_defines.svh
// Assertion macros shared by the glyph_to_vector_commands design files.
`ifndef GLYPH_TO_VECTOR_COMMANDS_DEFINES_SVH
`define GLYPH_TO_VECTOR_COMMANDS_DEFINES_SVH

`ifndef ASSERT_OFF
`define GTVC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GTVC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GTVC_ASSERT(lbl, clk, rst_n, prop, msg)
`define GTVC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: design/gtvc_pkg.sv
// Types, constants and glyph ROM for the glyph to vector command block.
package gtvc_pkg;

    localparam int ROW_LEN     = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [7:0] MARK_UP  = 8'hFE;
    localparam logic [7:0] MARK_END = 8'hFF;

    localparam logic [2:0] SVEC_TAG = 3'b010;

    localparam logic [2:0] LIT_RESET = 3'd2;
    localparam logic [3:0] ADV_RESET = 4'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIT_BRIGHTNESS = 1'b0,
        REG_ADVANCE_WIDTH  = 1'b1
    } t_cfg_reg;

    typedef logic [$clog2(ROW_LEN)-1:0] t_row_idx;
    typedef logic [0:ROW_LEN-1][7:0]    t_glyph_row;

    // one queued command: a stroke point or the final cell advance
    typedef struct packed {
        logic       adv;
        logic       dark;
        logic [3:0] x;
        logic [3:0] y;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_xfer;

    function automatic t_glyph_row glyph_row(input logic [6:0] code);
        t_glyph_row row;
        case (code)
            7'h20: row = 64'hFF00_0000_0000_0000;
            7'h21: row = 64'h4032_5240_FE44_4CFF;
            7'h22: row = 64'h2A26_FE6A_66FF_0000;
            7'h23: row = 64'h0484_626A_8808_2A22;
            7'h24: row = 64'h6226_6AFE_4C40_FF00;
            7'h25: row = 64'h008C_FE2A_28FE_6462;
            7'h26: row = 64'h804C_8804_4084_FF00;
            7'h27: row = 64'h266A_FF00_0000_0000;
            7'h28: row = 64'h6024_286C_FF00_0000;
            7'h29: row = 64'h2064_682C_FF00_0000;
            7'h2A: row = 64'h004C_8008_8800_FF00;
            7'h2B: row = 64'h1676_FE49_43FF_0000;
            7'h2C: row = 64'h2042_FF00_0000_0000;
            7'h2D: row = 64'h2666_FF00_0000_0000;
            7'h2E: row = 64'h3040_FF00_0000_0000;
            7'h2F: row = 64'h008C_FF00_0000_0000;
            7'h30: row = 64'h0080_8C0C_008C_FF00;
            7'h31: row = 64'h404C_3AFF_0000_0000;
            7'h32: row = 64'h0C8C_8705_0080_FF00;
            7'h33: row = 64'h0C8C_8000_FE06_86FF;
            7'h34: row = 64'h0C06_86FE_8C80_FF00;
            7'h35: row = 64'h0080_8607_0C8C_FF00;
            7'h36: row = 64'h0C00_8085_07FF_0000;
            7'h37: row = 64'h0C8C_8640_FF00_0000;
            7'h38: row = 64'h0080_8C0C_00FE_0686;
            7'h39: row = 64'h808C_0C07_85FF_0000;
            7'h3A: row = 64'h4947_FE45_43FF_0000;
            7'h3B: row = 64'h4947_FE45_12FF_0000;
            7'h3C: row = 64'h6026_6CFF_0000_0000;
            7'h3D: row = 64'h1474_FE18_78FF_0000;
            7'h3E: row = 64'h2066_2CFF_0000_0000;
            7'h3F: row = 64'h084C_8844_FE41_40FF;
            7'h40: row = 64'h8440_0408_4C88_4436;
            7'h41: row = 64'h0008_4C88_80FE_0484;
            7'h42: row = 64'h000C_4C8A_4682_4000;
            7'h43: row = 64'h8000_0C8C_FF00_0000;
            7'h44: row = 64'h000C_4C88_8440_00FF;
            7'h45: row = 64'h8000_0C8C_FE06_66FF;
            7'h46: row = 64'h000C_8CFE_0666_FF00;
            7'h47: row = 64'h6684_8000_0C8C_FF00;
            7'h48: row = 64'h000C_FE06_86FE_8C80;
            7'h49: row = 64'h0080_FE40_4CFE_0C8C;
            7'h4A: row = 64'h0440_808C_FF00_0000;
            7'h4B: row = 64'h000C_FE8C_0660_FF00;
            7'h4C: row = 64'h8000_0CFF_0000_0000;
            7'h4D: row = 64'h000C_488C_80FF_0000;
            7'h4E: row = 64'h000C_808C_FF00_0000;
            7'h4F: row = 64'h000C_8C80_00FF_0000;
            7'h50: row = 64'h000C_8C86_05FF_0000;
            7'h51: row = 64'h000C_8C84_00FE_4480;
            7'h52: row = 64'h000C_8C86_05FE_4580;
            7'h53: row = 64'h0220_8085_070C_6C8A;
            7'h54: row = 64'h0C8C_FE4C_40FF_0000;
            7'h55: row = 64'h0C02_4082_8CFF_0000;
            7'h56: row = 64'h0C40_8CFF_0000_0000;
            7'h57: row = 64'h0C20_4460_8CFF_0000;
            7'h58: row = 64'h008C_FE0C_80FF_0000;
            7'h59: row = 64'h0C46_8CFE_4640_FF00;
            7'h5A: row = 64'h0C8C_0080_FE26_66FF;
            7'h5B: row = 64'h6020_2C6C_FF00_0000;
            7'h5C: row = 64'h0C80_FF00_0000_0000;
            7'h5D: row = 64'h2060_6C2C_FF00_0000;
            7'h5E: row = 64'h264C_66FF_0000_0000;
            7'h5F: row = 64'h0080_FF00_0000_0000;
            7'h60: row = 64'h2A66_FF00_0000_0000;
            7'h7B: row = 64'h6042_4A6C_FE26_46FF;
            7'h7C: row = 64'h4045_FE46_4CFF_0000;
            7'h7D: row = 64'h4062_6A4C_FE66_86FF;
            7'h7E: row = 64'h0428_6488_FF00_0000;
            default: row = '0;
        endcase
        return row;
    endfunction

    function automatic logic [7:0] glyph_byte(input logic [6:0] code, input t_row_idx idx);
        t_glyph_row row;
        row = glyph_row(code);
        return row[idx];
    endfunction

endpackage

FILE: design/gtvc_front.sv
// Front end: accepts a character, walks its glyph row and queues point and advance commands.
`include "glyph_to_vector_commands_defines.svh"

module gtvc_front #(
    parameter int STROKES_PER_GLYPH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [6:0]        i_char_code,
    input  logic              i_done,
    input  logic              i_q_full,
    output logic              o_busy,
    output gtvc_pkg::t_q_xfer o_push
);

    localparam int IDX_W = $clog2(STROKES_PER_GLYPH + 1);

    typedef enum logic {
        F_IDLE,
        F_RUN
    } t_fstate;

    t_fstate          r_state, n_state;
    logic             r_busy, n_busy;
    logic [6:0]       r_code, n_code;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_dark, n_dark;
    logic [7:0]       w_byte;
    logic             w_end;
    logic             w_accept;

    assign w_accept = i_start && !r_busy;

    always_comb begin
        if (32'(r_idx) >= gtvc_pkg::ROW_LEN) begin
            w_byte = gtvc_pkg::MARK_END;
        end else begin
            w_byte = gtvc_pkg::glyph_byte(r_code, gtvc_pkg::t_row_idx'(r_idx));
        end
        w_end = (r_idx == IDX_W'(STROKES_PER_GLYPH)) || (w_byte == gtvc_pkg::MARK_END);
    end

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_code  = r_code;
        n_idx   = r_idx;
        n_dark  = r_dark;
        o_push  = '0;
        if (i_done) begin
            n_busy = 1'b0;
        end
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_state = F_RUN;
                    n_busy  = 1'b1;
                    n_code  = i_char_code;
                    n_idx   = '0;
                    n_dark  = 1'b1;
                end
            end
            F_RUN: begin
                if (!i_q_full) begin
                    if (w_end) begin
                        o_push.valid    = 1'b1;
                        o_push.cmd.adv  = 1'b1;
                        n_state         = F_IDLE;
                    end else if (w_byte == gtvc_pkg::MARK_UP) begin
                        n_dark = 1'b1;
                        n_idx  = r_idx + 1'b1;
                    end else begin
                        o_push.valid    = 1'b1;
                        o_push.cmd.dark = r_dark;
                        o_push.cmd.x    = w_byte[7:4];
                        o_push.cmd.y    = w_byte[3:0];
                        n_dark          = 1'b0;
                        n_idx           = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_dark  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_idx   <= n_idx;
            r_dark  <= n_dark;
        end
        r_code <= n_code;
    end

    assign o_busy = r_busy;

    `GTVC_ASSERT_NEVER(a_idx_range, i_clk, i_rst_n,
        r_state == F_RUN && r_idx > IDX_W'(STROKES_PER_GLYPH), "stroke index past glyph length")
    `GTVC_ASSERT(a_run_busy, i_clk, i_rst_n,
        r_state == F_RUN |-> r_busy, "walking a glyph while not busy")

endmodule

FILE: design/gtvc_queue.sv
// Small command queue between the front end and the back end.
`include "glyph_to_vector_commands_defines.svh"

module gtvc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gtvc_pkg::t_q_xfer i_push,
    output logic              o_full,
    output gtvc_pkg::t_q_xfer o_pop
);

    localparam int PTR_W = $clog2(gtvc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(gtvc_pkg::QUEUE_DEPTH + 1);

    gtvc_pkg::t_cmd   r_mem [gtvc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_pop;
    logic             w_push;

    assign o_full    = (r_count == CNT_W'(gtvc_pkg::QUEUE_DEPTH));
    assign w_pop     = (r_count != '0);
    assign w_push    = i_push.valid && !o_full;
    assign o_pop.valid = w_pop;
    assign o_pop.cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (w_push) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end

    `GTVC_ASSERT_NEVER(a_push_full, i_clk, i_rst_n,
        i_push.valid && o_full, "push into a full command queue")
    `GTVC_ASSERT(a_count_step, i_clk, i_rst_n,
        i_push.valid && !w_pop |=> r_count == $past(r_count) + 1'b1, "queue count lost a push")

endmodule

FILE: design/gtvc_back.sv
// Back end: turns queued commands into relative short-vector words.
module gtvc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gtvc_pkg::t_q_xfer i_pop,
    input  logic [2:0]        i_lit_brightness,
    input  logic [3:0]        i_advance_width,
    output logic              o_done,
    output logic              o_strobe,
    output logic [15:0]       o_command_word,
    output logic              o_last_word
);

    logic [3:0]  r_x, n_x;
    logic [3:0]  r_y, n_y;
    logic        r_strobe;
    logic [15:0] r_word, n_word;
    logic        r_last, n_last;
    logic [4:0]  w_dx;
    logic [4:0]  w_dy;
    logic [2:0]  w_bright;

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        if (i_pop.cmd.adv) begin
            w_dx     = {1'b0, i_advance_width} - {1'b0, r_x};
            w_dy     = 5'd0 - {1'b0, r_y};
            w_bright = 3'd0;
            n_last   = 1'b1;
        end else begin
            w_dx     = {1'b0, i_pop.cmd.x} - {1'b0, r_x};
            w_dy     = {1'b0, i_pop.cmd.y} - {1'b0, r_y};
            w_bright = i_pop.cmd.dark ? 3'd0 : i_lit_brightness;
            n_last   = 1'b0;
        end
        n_word = {gtvc_pkg::SVEC_TAG, w_dy, w_bright, w_dx};
        if (i_pop.valid) begin
            n_x = i_pop.cmd.adv ? 4'd0 : i_pop.cmd.x;
            n_y = i_pop.cmd.adv ? 4'd0 : i_pop.cmd.y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_strobe <= i_pop.valid;
        end
        if (i_pop.valid) begin
            r_word <= n_word;
            r_last <= n_last;
        end
    end

    assign o_done         = i_pop.valid && i_pop.cmd.adv;
    assign o_strobe       = r_strobe;
    assign o_command_word = r_word;
    assign o_last_word    = r_last;

endmodule

FILE: design/glyph_to_vector_commands.sv
// Top level of the glyph to short-vector command generator.
// Usage:
//   Pulse start with a character code on i_char_code while busy is low; the
//   transaction is taken at that edge and busy rises. Codes 32..96, 123..126
//   select a glyph; any other code draws like an empty glyph (eight zero moves).
//   Results come out one word per cycle on o_command_word, marked by
//   o_strobe for one cycle each; o_last_word flags the final cell advance.
//   The receiver cannot stall, so every strobe is a delivered transaction.
// Timing:
//   The front end reads one glyph byte per cycle from the ROM while the queue
//   is not full, then queues the advance; the back end emits one word per
//   cycle behind it. The first word passes the front-end state register, the
//   queue and the back-end output register before its strobe rises. The walk
//   stops at the end mark or after STROKES_PER_GLYPH bytes; the word carrying
//   o_last_word shows while busy is already low.
// Reset:
//   Synchronous, active low; the registers return to brightness 2 and
//   advance 12, the pen to the origin. Write the registers through
//   i_cfg_we / i_cfg_idx / i_cfg_wdata only while busy is low.
`include "glyph_to_vector_commands_defines.svh"

module glyph_to_vector_commands #(
    parameter int STROKES_PER_GLYPH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [6:0]                     i_char_code,
    input  logic                           i_cfg_we,
    input  logic [gtvc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gtvc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                           o_strobe,
    output logic [15:0]                    o_command_word,
    output logic                           o_last_word
);

    logic [2:0]        r_lit;
    logic [3:0]        r_adv;
    gtvc_pkg::t_q_xfer w_push;
    gtvc_pkg::t_q_xfer w_pop;
    logic              w_full;
    logic              w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit <= gtvc_pkg::LIT_RESET;
            r_adv <= gtvc_pkg::ADV_RESET;
        end else if (i_cfg_we) begin
            unique case (gtvc_pkg::t_cfg_reg'(i_cfg_idx))
                gtvc_pkg::REG_LIT_BRIGHTNESS: r_lit <= i_cfg_wdata[2:0];
                gtvc_pkg::REG_ADVANCE_WIDTH:  r_adv <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    gtvc_front #(
        .STROKES_PER_GLYPH(STROKES_PER_GLYPH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_char_code(i_char_code),
        .i_done     (w_done),
        .i_q_full   (w_full),
        .o_busy     (busy),
        .o_push     (w_push)
    );

    gtvc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .o_full (w_full),
        .o_pop  (w_pop)
    );

    gtvc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pop           (w_pop),
        .i_lit_brightness(r_lit),
        .i_advance_width (r_adv),
        .o_done          (w_done),
        .o_strobe        (o_strobe),
        .o_command_word  (o_command_word),
        .o_last_word     (o_last_word)
    );

    `GTVC_ASSERT(a_start_busy, i_clk, i_rst_n,
        start && !busy |=> busy, "accepted character did not raise busy")
    `GTVC_ASSERT(a_strobe_in_item, i_clk, i_rst_n,
        o_strobe |-> $past(busy), "result word outside a character")
    `GTVC_ASSERT(a_last_idle, i_clk, i_rst_n,
        o_strobe && o_last_word |-> !busy, "busy still high on the final advance word")

endmodule

FILE: test/testbench.sv
// Testbench for glyph_to_vector_commands: directed table plus random glyphs vs. a predictor.
`timescale 1ns / 100ps

module testbench;

    localparam int STROKES    = 8;
    localparam int RAND_ITEMS = 450;

    typedef enum logic [1:0] {
        ROW_GLYPH,
        ROW_KNOWN,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        gtvc_pkg::t_cfg_reg cfg_reg;
        logic [6:0]         value;
        logic [15:0]        exp_word;
    } t_stim_row;

    typedef struct packed {
        logic [15:0] word;
        logic        last;
    } t_vec_word;

    localparam t_stim_row DIR_ROWS [22] = '{
        '{ROW_KNOWN, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h20, 16'h400C},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h30, 16'h0},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h00, 16'h0},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h7F, 16'h0},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h1F, 16'h0},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h7E, 16'h0},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h61, 16'h0},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h38, 16'h0},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h23, 16'h0},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h48, 16'h0},
        '{ROW_REG,   gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h07, 16'h0},
        '{ROW_REG,   gtvc_pkg::REG_ADVANCE_WIDTH,  7'h0F, 16'h0},
        '{ROW_KNOWN, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h20, 16'h400F},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h25, 16'h0},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h42, 16'h0},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h00, 16'h0},
        '{ROW_REG,   gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h00, 16'h0},
        '{ROW_REG,   gtvc_pkg::REG_ADVANCE_WIDTH,  7'h00, 16'h0},
        '{ROW_KNOWN, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h20, 16'h4000},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h40, 16'h0},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h53, 16'h0},
        '{ROW_GLYPH, gtvc_pkg::REG_LIT_BRIGHTNESS, 7'h5C, 16'h0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [6:0]  i_char_code;
    logic        i_cfg_we;
    logic [gtvc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [gtvc_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic        o_strobe;
    logic [15:0] o_command_word;
    logic        o_last_word;

    t_vec_word   pending_words[$];
    logic [2:0]  lit_shadow;
    logic [3:0]  adv_shadow;
    logic        idle_on;
    int          error_count;

    glyph_to_vector_commands u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_char_code    (i_char_code),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_command_word (o_command_word),
        .o_last_word    (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Stroke bytes per glyph, byte 0 in the top bits; unlisted codes are all zeros.
    function automatic logic [63:0] stroke_row(input logic [6:0] code);
        logic [63:0] row;
        case ({1'b0, code})
            " ":  row = 64'hFF00_0000_0000_0000;
            "!":  row = 64'h4032_5240_FE44_4CFF;
            "\"": row = 64'h2A26_FE6A_66FF_0000;
            "#":  row = 64'h0484_626A_8808_2A22;
            "$":  row = 64'h6226_6AFE_4C40_FF00;
            "%":  row = 64'h008C_FE2A_28FE_6462;
            "&":  row = 64'h804C_8804_4084_FF00;
            "'":  row = 64'h266A_FF00_0000_0000;
            "(":  row = 64'h6024_286C_FF00_0000;
            ")":  row = 64'h2064_682C_FF00_0000;
            "*":  row = 64'h004C_8008_8800_FF00;
            "+":  row = 64'h1676_FE49_43FF_0000;
            ",":  row = 64'h2042_FF00_0000_0000;
            "-":  row = 64'h2666_FF00_0000_0000;
            ".":  row = 64'h3040_FF00_0000_0000;
            "/":  row = 64'h008C_FF00_0000_0000;
            "0":  row = 64'h0080_8C0C_008C_FF00;
            "1":  row = 64'h404C_3AFF_0000_0000;
            "2":  row = 64'h0C8C_8705_0080_FF00;
            "3":  row = 64'h0C8C_8000_FE06_86FF;
            "4":  row = 64'h0C06_86FE_8C80_FF00;
            "5":  row = 64'h0080_8607_0C8C_FF00;
            "6":  row = 64'h0C00_8085_07FF_0000;
            "7":  row = 64'h0C8C_8640_FF00_0000;
            "8":  row = 64'h0080_8C0C_00FE_0686;
            "9":  row = 64'h808C_0C07_85FF_0000;
            ":":  row = 64'h4947_FE45_43FF_0000;
            ";":  row = 64'h4947_FE45_12FF_0000;
            "<":  row = 64'h6026_6CFF_0000_0000;
            "=":  row = 64'h1474_FE18_78FF_0000;
            ">":  row = 64'h2066_2CFF_0000_0000;
            "?":  row = 64'h084C_8844_FE41_40FF;
            "@":  row = 64'h8440_0408_4C88_4436;
            "A":  row = 64'h0008_4C88_80FE_0484;
            "B":  row = 64'h000C_4C8A_4682_4000;
            "C":  row = 64'h8000_0C8C_FF00_0000;
            "D":  row = 64'h000C_4C88_8440_00FF;
            "E":  row = 64'h8000_0C8C_FE06_66FF;
            "F":  row = 64'h000C_8CFE_0666_FF00;
            "G":  row = 64'h6684_8000_0C8C_FF00;
            "H":  row = 64'h000C_FE06_86FE_8C80;
            "I":  row = 64'h0080_FE40_4CFE_0C8C;
            "J":  row = 64'h0440_808C_FF00_0000;
            "K":  row = 64'h000C_FE8C_0660_FF00;
            "L":  row = 64'h8000_0CFF_0000_0000;
            "M":  row = 64'h000C_488C_80FF_0000;
            "N":  row = 64'h000C_808C_FF00_0000;
            "O":  row = 64'h000C_8C80_00FF_0000;
            "P":  row = 64'h000C_8C86_05FF_0000;
            "Q":  row = 64'h000C_8C84_00FE_4480;
            "R":  row = 64'h000C_8C86_05FE_4580;
            "S":  row = 64'h0220_8085_070C_6C8A;
            "T":  row = 64'h0C8C_FE4C_40FF_0000;
            "U":  row = 64'h0C02_4082_8CFF_0000;
            "V":  row = 64'h0C40_8CFF_0000_0000;
            "W":  row = 64'h0C20_4460_8CFF_0000;
            "X":  row = 64'h008C_FE0C_80FF_0000;
            "Y":  row = 64'h0C46_8CFE_4640_FF00;
            "Z":  row = 64'h0C8C_0080_FE26_66FF;
            "[":  row = 64'h6020_2C6C_FF00_0000;
            "\\": row = 64'h0C80_FF00_0000_0000;
            "]":  row = 64'h2060_6C2C_FF00_0000;
            "^":  row = 64'h264C_66FF_0000_0000;
            "_":  row = 64'h0080_FF00_0000_0000;
            8'h60: row = 64'h2A66_FF00_0000_0000;   // grave accent
            "{":  row = 64'h6042_4A6C_FE26_46FF;
            "|":  row = 64'h4045_FE46_4CFF_0000;
            "}":  row = 64'h4062_6A4C_FE66_86FF;
            "~":  row = 64'h0428_6488_FF00_0000;
            default: row = '0;
        endcase
        return row;
    endfunction

    function automatic logic [15:0] vec_word(input logic [4:0] dx, input logic [4:0] dy,
                                             input logic [2:0] bright);
        return {gtvc_pkg::SVEC_TAG, dy, bright, dx};
    endfunction

    task automatic expand_glyph(input logic [6:0] code);
        logic [63:0] row;
        logic [7:0]  b;
        logic [3:0]  px;
        logic [3:0]  py;
        logic [2:0]  bright;
        row    = stroke_row(code);
        px     = '0;
        py     = '0;
        bright = '0;
        for (int i = 0; i < STROKES; i++) begin
            b = row[63-8*i -: 8];
            if (b == gtvc_pkg::MARK_END) break;
            if (b == gtvc_pkg::MARK_UP) begin
                bright = '0;
            end else begin
                pending_words.push_back('{vec_word({1'b0, b[7:4]} - {1'b0, px},
                                                   {1'b0, b[3:0]} - {1'b0, py}, bright), 1'b0});
                bright = lit_shadow;
                px     = b[7:4];
                py     = b[3:0];
            end
        end
        pending_words.push_back('{vec_word({1'b0, adv_shadow} - {1'b0, px},
                                           5'd0 - {1'b0, py}, 3'd0), 1'b1});
    endtask

    task automatic flag_error(input string what, input logic [15:0] want, input logic [15:0] got);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_vec_word exp_word;
        if (i_rst_n && o_strobe) begin
            if (pending_words.size() == 0) begin
                flag_error("unexpected word", 16'h0, o_command_word);
            end else begin
                exp_word = pending_words.pop_front();
                if (o_command_word !== exp_word.word)
                    flag_error("command_word", exp_word.word, o_command_word);
                if (o_last_word !== exp_word.last)
                    flag_error("last_word", {15'd0, exp_word.last}, {15'd0, o_last_word});
            end
        end
    end

    task automatic send_glyph(input logic [6:0] code, input logic known,
                              input logic [15:0] known_word);
        if (idle_on && $urandom_range(99) < 17) begin
            start = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end
        start       = 1'b1;
        i_char_code = code;
        do @(posedge i_clk); while (busy);
        if (known)
            pending_words.push_back('{known_word, 1'b1});
        else
            expand_glyph(code);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (pending_words.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input gtvc_pkg::t_cfg_reg idx, input logic [3:0] val);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == gtvc_pkg::REG_LIT_BRIGHTNESS)
            lit_shadow = val[2:0];
        else
            adv_shadow = val;
    endtask

    function automatic logic [3:0] pick_setting();
        case ($urandom_range(2))
            0:       return 4'h0;
            1:       return 4'hF;
            default: return 4'($urandom_range(15));
        endcase
    endfunction

    initial begin
        logic [6:0] code;
        start       = 1'b0;
        i_char_code = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = gtvc_pkg::REG_LIT_BRIGHTNESS;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        error_count = 0;
        idle_on     = 1'b1;
        lit_shadow  = gtvc_pkg::LIT_RESET;
        adv_shadow  = gtvc_pkg::ADV_RESET;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (DIR_ROWS[r]) begin
            case (DIR_ROWS[r].kind)
                ROW_REG:   write_reg(DIR_ROWS[r].cfg_reg, DIR_ROWS[r].value[3:0]);
                ROW_KNOWN: send_glyph(DIR_ROWS[r].value, 1'b1, DIR_ROWS[r].exp_word);
                default:   send_glyph(DIR_ROWS[r].value, 1'b0, 16'h0);
            endcase
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 75 == 0) begin
                write_reg(gtvc_pkg::REG_LIT_BRIGHTNESS, pick_setting());
                write_reg(gtvc_pkg::REG_ADVANCE_WIDTH, pick_setting());
            end
            if (n == 260)
                wait_drained();
            idle_on = !(n >= 100 && n < 200);
            if ($urandom_range(99) < 75)
                code = 7'($urandom_range(126, 32));
            else
                code = 7'($urandom_range(127, 0));
            send_glyph(code, 1'b0, 16'h0);
        end

        start = 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: glyph_to_vector_commands.f
+incdir+design
design/gtvc_pkg.sv
design/gtvc_front.sv
design/gtvc_queue.sv
design/gtvc_back.sv
design/glyph_to_vector_commands.sv
test/testbench.sv
